>>> hdl/sida_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg: shared constants, types and functions
// Word and digit sizing, character codes and the shift-and-add-3 step
// used by the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int WORD_BITS = 32;

	// Decimal digits of the largest magnitude, 2**(WORD_BITS-1).
	// 1233/4096 approximates log10(2) closely enough over 8..64 bits.
	localparam int DIGITS = ((WORD_BITS - 1) * 1233) / 4096 + 1;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int IDX_W  = $clog2(DIGITS);

	// Binary to BCD conversion runs DABBLE_STEPS bit steps per stage.
	localparam int DABBLE_STEPS = 8;
	localparam int NCONV        = (WORD_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;
	localparam int PAD_W        = NCONV * DABBLE_STEPS;

	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

	typedef struct packed {
		logic [PAD_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} conv_t;

	// One stage worth of double dabble: correct each digit, then shift one
	// binary bit into the BCD accumulator, most significant bit first.
	function automatic conv_t dabble_steps(conv_t c);
		conv_t r;
		r = c;
		for (int s = 0; s < DABBLE_STEPS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (r.bcd[d*4 +: 4] >= 4'd5) begin
					r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
				end
			end
			{r.bcd, r.bin} = {r.bcd, r.bin} << 1;
		end
		return r;
	endfunction

	// Index of the most significant non-zero digit, zero when all are zero.
	function automatic logic [IDX_W-1:0] top_digit(logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] t;
		t = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd[d*4 +: 4] != 4'd0) begin
				t = IDX_W'(d);
			end
		end
		return t;
	endfunction

endpackage
`default_nettype wire

>>> hdl/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement word per input beat into its decimal text,
// one character per output beat, minus sign first, no leading zeros.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload             Beats per number
//   input     value_valid / value_ready value               1
//   output    char_valid / char_ready   ascii_char, last    1 to DIGITS + 1
//
// Path: an input beat is registered in a magnitude stage at its accepting
// edge, then passes NCONV double dabble stages (four at 32 bits), the
// character serialiser and the output register before its first character
// is presented. Each number yields 1 to 11 characters at 32 bits; the
// serialiser, one character per cycle while the output is not stalled, sets
// the sustained rate, and consecutive numbers follow with no gap.
// Reset clears every valid bit and the serialiser's busy flag; payload
// registers are not reset. A stall on the output holds the output register
// and backs up through the serialiser and the pipeline stage by stage;
// nothing is dropped or repeated.
//
module signed_int_to_decimal_ascii
	import sida_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic signed [WORD_BITS-1:0] value,
	input  logic                        value_valid,
	output logic                        value_ready,

	output logic [CHAR_W-1:0]           ascii_char,
	output logic                        last,
	output logic                        char_valid,
	input  logic                        char_ready
);

	// ------------------------------------------------------------------
	// Stage 1: sign and magnitude. The most negative value negates to
	// 2**(WORD_BITS-1), which is still exact as an unsigned word.
	// ------------------------------------------------------------------
	logic                 vld_s1;
	logic                 neg_s1;
	logic [WORD_BITS-1:0] mag_s1;
	logic                 ready_s1;

	// Conversion stages, one entry per stage.
	logic  cvld_s  [NCONV];
	logic  cneg_s  [NCONV];
	conv_t conv_s  [NCONV];
	logic  cready  [NCONV];
	logic  ctake   [NCONV];

	// Serialiser state.
	logic             ser_busy_q;
	logic             ser_neg_q;
	logic [IDX_W-1:0] ser_idx_q;
	logic [BCD_W-1:0] ser_bcd_q;
	logic             ser_final;
	logic             ser_can_load;

	// Output register.
	logic              char_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              out_load;
	logic [3:0]        cur_digit;

	assign ready_s1    = !vld_s1 || cready[0];
	assign value_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && value_valid) begin
			neg_s1 <= value[WORD_BITS-1];
			mag_s1 <= value[WORD_BITS-1] ? (~$unsigned(value)) + WORD_BITS'(1)
				: $unsigned(value);
		end
	end

	// ------------------------------------------------------------------
	// Double dabble pipeline: each stage shifts DABBLE_STEPS bits of the
	// zero-padded magnitude into the BCD accumulator.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < NCONV; k++) begin : g_conv
		logic  up_vld;
		logic  up_neg;
		conv_t up_conv;

		if (k == 0) begin : g_first
			always_comb begin
				up_vld      = vld_s1;
				up_neg      = neg_s1;
				up_conv.bin = PAD_W'(mag_s1);
				up_conv.bcd = '0;
			end
		end else begin : g_next
			always_comb begin
				up_vld  = cvld_s[k-1];
				up_neg  = cneg_s[k-1];
				up_conv = conv_s[k-1];
			end
		end

		if (k == NCONV - 1) begin : g_tail
			assign ctake[k] = ser_can_load;
		end else begin : g_mid
			assign ctake[k] = cready[k+1];
		end

		assign cready[k] = !cvld_s[k] || ctake[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[k] <= 1'b0;
			end else if (cready[k]) begin
				cvld_s[k] <= up_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (cready[k] && up_vld) begin
				cneg_s[k] <= up_neg;
				conv_s[k] <= dabble_steps(up_conv);
			end
		end
	end

	// ------------------------------------------------------------------
	// Serialiser: emits the minus sign if any, then digits from the most
	// significant non-zero one down to the units digit. It takes the next
	// number in the cycle that its final character moves to the output
	// register, so numbers follow one another without a bubble.
	// ------------------------------------------------------------------
	assign out_load     = !char_valid_q || char_ready;
	assign ser_final    = ser_busy_q && !ser_neg_q && (ser_idx_q == '0);
	assign ser_can_load = !ser_busy_q || (out_load && ser_final);
	assign cur_digit    = ser_bcd_q[ser_idx_q*4 +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy_q <= 1'b0;
			ser_neg_q  <= 1'b0;
		end else begin
			if (ser_can_load && cvld_s[NCONV-1]) begin
				ser_busy_q <= 1'b1;
				ser_neg_q  <= cneg_s[NCONV-1];
			end else if (out_load && ser_busy_q) begin
				if (ser_neg_q) begin
					ser_neg_q <= 1'b0;
				end else if (ser_idx_q == '0) begin
					ser_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && ser_busy_q && !ser_neg_q && (ser_idx_q != '0)) begin
			ser_idx_q <= ser_idx_q - IDX_W'(1);
		end
		if (ser_can_load && cvld_s[NCONV-1]) begin
			ser_bcd_q <= conv_s[NCONV-1].bcd;
			ser_idx_q <= top_digit(conv_s[NCONV-1].bcd);
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (out_load) begin
			char_valid_q <= ser_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && ser_busy_q) begin
			if (ser_neg_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + CHAR_W'(cur_digit);
				last_q <= (ser_idx_q == '0);
			end
		end
	end

	assign char_valid = char_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (ascii_char == CHAR_MINUS) ||
			((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE)))
		else $error("output character outside the minus sign and digits");

	a_last_on_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && last) |-> (ascii_char != CHAR_MINUS))
		else $error("last flagged on a minus sign");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && !last) |=>
			!(char_valid && (ascii_char == CHAR_MINUS)))
		else $error("minus sign inside a number's text");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_busy_q |-> ({1'b0, ser_idx_q} < (IDX_W + 1)'(DIGITS)))
		else $error("serialiser digit index beyond the digit count");

	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && !last) |=> ser_busy_q || char_valid)
		else $error("number's text ended without a last character");

endmodule
`default_nettype wire
